/* sv/colormap_level_to_rgb_unit_defines.svh */
// Assertion macros for the colormap unit. Clock and reset are named clock and reset.
`ifndef COLORMAP_LEVEL_TO_RGB_UNIT_DEFINES_SVH
`define COLORMAP_LEVEL_TO_RGB_UNIT_DEFINES_SVH

// cond holds -> cons holds in the same cycle
`define CLM_ASSERT_SAME(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// cond holds -> cons holds in the next cycle
`define CLM_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

/* sv/clm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package clm_pkg;

   localparam int unsigned LEVEL_BITS = 8;
   localparam int unsigned CHAN_BITS  = 8;
   localparam int unsigned MAP_BITS   = 4;
   localparam int unsigned BASE_BITS  = 12;
   localparam int unsigned NUM_BITS   = 18;
   localparam int unsigned PROD_BITS  = 37;

   // floor(x / 255) = ((x + DIV_OFFSET) * DIV_RECIP >> DIV_SHIFT) - 255 for the ranges used here
   localparam int unsigned DIV_OFFSET = 65025;
   localparam int unsigned DIV_RECIP  = 263173;
   localparam int unsigned DIV_SHIFT  = 26;
   localparam logic [63:0] Q30        = 64'd1 << 30;

   typedef enum logic [MAP_BITS-1:0] {
      MAP_NONE      = 4'd0,
      MAP_GRAY      = 4'd1,
      MAP_TRAD      = 4'd2,
      MAP_HOT       = 4'd3,
      MAP_RAINBOW   = 4'd4,
      MAP_JET       = 4'd5,
      MAP_BLACKJET  = 4'd6,
      MAP_WHITEJET  = 4'd7,
      MAP_WJSHADOW  = 4'd8,
      MAP_GRAD16    = 4'd9,
      MAP_GRAD7     = 4'd10,
      MAP_WHEEL     = 4'd11
   } map_sel_type;

   localparam logic [7:0] G16_TAB [16][3] = '{
      '{8'd0,8'd0,8'd0},     '{8'd0,8'd0,8'd0},     '{8'd0,8'd0,8'd35},
      '{8'd0,8'd2,8'd73},    '{8'd4,8'd64,8'd103},  '{8'd17,8'd118,8'd99},
      '{8'd25,8'd151,8'd58}, '{8'd24,8'd144,8'd0},  '{8'd98,8'd108,8'd0},
      '{8'd187,8'd15,8'd0},  '{8'd206,8'd43,8'd0},  '{8'd215,8'd84,8'd0},
      '{8'd225,8'd125,8'd0}, '{8'd234,8'd168,8'd0}, '{8'd244,8'd211,8'd0},
      '{8'd254,8'd251,8'd0}};

   localparam logic [7:0] G7_TAB [7][3] = '{
      '{8'd0,8'd0,8'd0},     '{8'd28,8'd30,8'd31},  '{8'd0,8'd24,8'd255},
      '{8'd0,8'd139,8'd211}, '{8'd247,8'd134,8'd0}, '{8'd255,8'd255,8'd0},
      '{8'd255,8'd255,8'd255}};

   // 255 * sin(pi/2 * n / 255), quarter-wave series in Q30, negative half gives 0
   function automatic logic [7:0] sine8(input int unsigned n);
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] o;
      q = 64'd0;
      r = 64'(n);
      for (int j = 0; j < 4; j++) begin
         if (r >= 64'd255) begin
            r = r - 64'd255;
            q = q + 64'd1;
         end
      end
      q = q & 64'd3;
      if (q >= 64'd2) return 8'd0;
      if (q == 64'd1) r = 64'd255 - r;
      x  = (64'd1686629713 * r) / 64'd255;
      x2 = (x * x) >> 30;
      t  = Q30;
      t  = Q30 - ((x2 * t) >> 30) / 64'd156;
      t  = Q30 - ((x2 * t) >> 30) / 64'd110;
      t  = Q30 - ((x2 * t) >> 30) / 64'd72;
      t  = Q30 - ((x2 * t) >> 30) / 64'd42;
      t  = Q30 - ((x2 * t) >> 30) / 64'd20;
      t  = Q30 - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      if (s > Q30) s = Q30;
      o = (64'd255 * s) >> 30;
      return o[7:0];
   endfunction

   // entry l holds sine8(down ? add - l : mul * l)
   function automatic logic [255:0][7:0] build_sine(input int unsigned mul,
                                                    input int unsigned add,
                                                    input bit down);
      logic [255:0][7:0] tab;
      for (int l = 0; l < 256; l++) begin
         tab[l] = sine8(down ? add - l : mul * l);
      end
      return tab;
   endfunction

   function automatic logic [255:0][7:0] build_sqrt();
      logic [255:0][7:0] tab;
      int unsigned r;
      r = 0;
      for (int l = 0; l < 256; l++) begin
         for (int j = 0; j < 16; j++) begin
            if ((r + 1) * (r + 1) <= 255 * l) r = r + 1;
         end
         tab[l] = 8'(r);
      end
      return tab;
   endfunction

   function automatic logic [255:0][7:0] build_cube();
      logic [255:0][7:0] tab;
      longint unsigned c;
      for (int l = 0; l < 256; l++) begin
         c = longint'(l) * l * l / 65025;
         tab[l] = 8'(c);
      end
      return tab;
   endfunction

   localparam logic [255:0][7:0] SQRT_TAB  = build_sqrt();
   localparam logic [255:0][7:0] CUBE_TAB  = build_cube();
   localparam logic [255:0][7:0] SIN4_TAB  = build_sine(4, 0, 1'b0);
   localparam logic [255:0][7:0] SIN2_TAB  = build_sine(2, 0, 1'b0);
   localparam logic [255:0][7:0] COSQ_TAB  = build_sine(0, 255, 1'b1);

endpackage
`default_nettype wire

/* sv/clm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module clm_datapath
   import clm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  advance,
   input  wire logic [LEVEL_BITS-1:0] level,
   input  wire logic [MAP_BITS-1:0]   map_sel,
   output logic      [CHAN_BITS-1:0]  red,
   output logic      [CHAN_BITS-1:0]  green,
   output logic      [CHAN_BITS-1:0]  blue
);

   typedef logic signed [2:0][BASE_BITS-1:0] base_type;
   typedef logic signed [NUM_BITS-1:0] num_type;

   // stage 1: per-map decode into base + floor(num / 255)
   base_type                   base_in, base1_ff, base2_ff;
   num_type                    num_in [3];
   num_type                    num1_ff [3];
   logic [PROD_BITS-1:0]       prod_in [3];
   logic [PROD_BITS-1:0]       prod_ff [3];
   logic [2:0][CHAN_BITS-1:0]  chan_in, chan_ff;

   logic signed [BASE_BITS-1:0] lv;
   logic [10:0]                 p6;
   logic [3:0]                  g16_i;
   logic [7:0]                  g16_off;
   logic [4:0]                  g16_t;
   logic [2:0]                  g7_i;
   logic [10:0]                 g7_off;
   logic [8:0]                  g7_t;
   logic [2:0]                  sec;
   logic [7:0]                  frac;
   logic [7:0]                  rest;
   logic signed [9:0]           dlt;
   base_type                    jet;

   function automatic base_type jet_upper(input logic signed [BASE_BITS-1:0] l);
      base_type b;
      if (l <= 12'sd95) begin
         b[0] = 12'sd0;          b[1] = 12'sd4 * l - 12'sd128; b[2] = 12'sd255;
      end else if (l <= 12'sd159) begin
         b[0] = 12'sd4 * l - 12'sd383; b[1] = 12'sd255;        b[2] = 12'sd637 - 12'sd4 * l;
      end else if (l <= 12'sd223) begin
         b[0] = 12'sd255;        b[1] = 12'sd892 - 12'sd4 * l; b[2] = 12'sd0;
      end else begin
         b[0] = 12'sd1147 - 12'sd4 * l; b[1] = 12'sd0;         b[2] = 12'sd0;
      end
      return b;
   endfunction

   always_comb begin
      lv  = signed'({4'd0, level});
      p6  = 11'(level) * 11'd6;
      jet = jet_upper(lv);

      g16_i = 4'd1;
      for (int k = 1; k < 15; k++) begin
         if (level > 8'(17 * k)) g16_i = g16_i + 4'd1;
      end
      g16_off = 8'(g16_i - 4'd1) * 8'd17;
      g16_t   = 5'(level - g16_off);

      g7_i = 3'd1;
      for (int k = 1; k < 6; k++) begin
         if ({level, 1'b0} > 9'(85 * k)) g7_i = g7_i + 3'd1;
      end
      g7_off = 11'(g7_i - 3'd1) * 11'd255;
      g7_t   = 9'(p6 - g7_off);

      sec = 3'd0;
      for (int k = 1; k < 6; k++) begin
         if (p6 >= 11'(255 * k)) sec = sec + 3'd1;
      end
      if (level == 8'd255) sec = 3'd0;
      frac = (level == 8'd255) ? 8'd0 : 8'(p6 - 11'(sec) * 11'd255);
      rest = 8'd255 - frac;

      dlt = 10'sd0;
      for (int c = 0; c < 3; c++) begin
         base_in[c] = 12'sd0;
         num_in[c]  = 18'sd0;
      end

      unique case (map_sel)
         MAP_GRAY: begin
            for (int c = 0; c < 3; c++) base_in[c] = lv;
         end
         MAP_TRAD: begin
            base_in[0] = signed'({4'd0, SQRT_TAB[level]});
            base_in[1] = signed'({4'd0, CUBE_TAB[level]});
            base_in[2] = signed'({4'd0, SIN4_TAB[level]});
         end
         MAP_HOT: begin
            base_in[0] = 12'sd3 * lv;
            base_in[1] = 12'sd3 * lv - 12'sd255;
            base_in[2] = 12'sd3 * lv - 12'sd510;
         end
         MAP_RAINBOW: begin
            base_in[0] = (level >= 8'd64) ? 12'sd2 * lv - 12'sd128 : 12'sd127 - 12'sd2 * lv;
            base_in[1] = signed'({4'd0, SIN2_TAB[level]});
            base_in[2] = signed'({4'd0, COSQ_TAB[level]});
         end
         MAP_JET: begin
            if (level <= 8'd31) base_in[2] = 12'sd4 * lv + 12'sd127;
            else base_in = jet;
         end
         MAP_BLACKJET: begin
            if (level <= 8'd31) num_in[2] = 18'(level) * 18'sd2720;
            else base_in = jet;
         end
         MAP_WHITEJET: begin
            if (level <= 8'd31) begin
               base_in[0] = 12'sd255 - 12'sd8 * lv;
               base_in[1] = 12'sd255 - 12'sd8 * lv;
               base_in[2] = 12'sd255;
            end else base_in = jet;
         end
         MAP_WJSHADOW: begin
            if (level <= 8'd31) begin
               for (int c = 0; c < 3; c++) base_in[c] = 12'sd255 - 12'sd8 * lv;
            end else if (level <= 8'd63) begin
               base_in[2] = 12'sd8 * lv - 12'sd255;
            end else if (level <= 8'd95) begin
               base_in[1] = 12'sd8 * lv - 12'sd510;
               base_in[2] = 12'sd255;
            end else base_in = jet;
         end
         MAP_GRAD16: begin
            for (int c = 0; c < 3; c++) begin
               dlt = signed'({2'd0, G16_TAB[g16_i][c]})
                   - signed'({2'd0, G16_TAB[g16_i - 4'd1][c]});
               base_in[c] = signed'({4'd0, G16_TAB[g16_i - 4'd1][c]});
               num_in[c]  = ({{8{dlt[9]}}, dlt} * signed'({13'd0, g16_t})) <<< 1;
            end
         end
         MAP_GRAD7: begin
            for (int c = 0; c < 3; c++) begin
               dlt = signed'({2'd0, G7_TAB[g7_i][c]})
                   - signed'({2'd0, G7_TAB[g7_i - 3'd1][c]});
               base_in[c] = signed'({4'd0, G7_TAB[g7_i - 3'd1][c]});
               num_in[c]  = {{8{dlt[9]}}, dlt} * signed'({9'd0, g7_t});
            end
         end
         MAP_WHEEL: begin
            unique case (sec)
               3'd0: begin base_in[0] = 12'sd255; base_in[1] = signed'({4'd0, frac}); end
               3'd1: begin base_in[0] = signed'({4'd0, rest}); base_in[1] = 12'sd255; end
               3'd2: begin base_in[1] = 12'sd255; base_in[2] = signed'({4'd0, frac}); end
               3'd3: begin base_in[1] = signed'({4'd0, rest}); base_in[2] = 12'sd255; end
               3'd4: begin base_in[0] = signed'({4'd0, frac}); base_in[2] = 12'sd255; end
               default: begin base_in[0] = 12'sd255; base_in[2] = signed'({4'd0, rest}); end
            endcase
         end
         default: begin
         end
      endcase
   end

   // stage 2: floor division by 255 through a reciprocal multiply
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod_in[c] = PROD_BITS'(NUM_BITS'(num1_ff[c] + NUM_BITS'(DIV_OFFSET)))
                    * PROD_BITS'(DIV_RECIP);
      end
   end

   // stage 3: add, clamp
   logic signed [12:0] sum [3];
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum[c] = 13'(signed'(base2_ff[c])) + signed'({2'd0, 11'(prod_ff[c] >> DIV_SHIFT)})
                - 13'sd255;
         if (sum[c] < 13'sd0) chan_in[c] = 8'd0;
         else if (sum[c] > 13'sd255) chan_in[c] = 8'd255;
         else chan_in[c] = sum[c][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         base1_ff <= base_in;
         num1_ff  <= num_in;
         base2_ff <= base1_ff;
         prod_ff  <= prod_in;
         chan_ff  <= chan_in;
      end
   end

   assign red   = chan_ff[0];
   assign green = chan_ff[1];
   assign blue  = chan_ff[2];

endmodule
`default_nettype wire

/* sv/colormap_level_to_rgb_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Colormap unit: maps an 8-bit level to an 8-bit red, green, blue triple for the map chosen
// in csr_write_data (0 none, 1 gray, 2 traditional, 3 hot, 4 rainbow, 5 jet, 6 black-jet,
// 7 white-jet, 8 white-jet-shadow, 9 16-stop gradient, 10 7-stop gradient, 11 hue wheel;
// other codes give black; gray after reset). One request per clock unless the output stalls,
// which freezes the whole pipe. Each result passes a decode and table stage, a reciprocal
// multiply stage for the divisions by 255, and a clamp stage that holds the output register.
// The map must be changed only while no request is in flight; the unit does not enforce it.
`include "colormap_level_to_rgb_unit_defines.svh"
module colormap_level_to_rgb_unit
   import clm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [MAP_BITS-1:0]   csr_write_data,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [LEVEL_BITS-1:0] req_level,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [CHAN_BITS-1:0]  rsp_red,
   output logic      [CHAN_BITS-1:0]  rsp_green,
   output logic      [CHAN_BITS-1:0]  rsp_blue
);

   logic [MAP_BITS-1:0] map_ff;
   logic                stage1_valid_ff, stage2_valid_ff, stage3_valid_ff;
   logic                advance;

   assign advance   = !stage3_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = stage3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff          <= MAP_GRAY;
         stage1_valid_ff <= 1'b0;
         stage2_valid_ff <= 1'b0;
         stage3_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) map_ff <= csr_write_data;
         if (advance) begin
            stage1_valid_ff <= req_valid;
            stage2_valid_ff <= stage1_valid_ff;
            stage3_valid_ff <= stage2_valid_ff;
         end
      end
   end

   clm_datapath u_datapath (
      .clock   (clock),
      .advance (advance),
      .level   (req_level),
      .map_sel (map_ff),
      .red     (rsp_red),
      .green   (rsp_green),
      .blue    (rsp_blue)
   );

   `CLM_ASSERT_NEXT(a_request_enters, req_valid && req_ready, stage1_valid_ff, "request lost at entry")
   `CLM_ASSERT_NEXT(a_stall_freezes, rsp_valid && !rsp_ready, $stable(stage1_valid_ff) && $stable(stage2_valid_ff) && rsp_valid, "pipe moved during stall")
   `CLM_ASSERT_NEXT(a_stage2_delivers, stage2_valid_ff && req_ready, rsp_valid, "result lost in last stage")
   `CLM_ASSERT_SAME(a_ready_when_empty, !rsp_valid, req_ready, "not ready with empty output")

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import clm_pkg::*;

   typedef struct {
      logic [7:0] level;
      int         gap;
   } level_req_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   localparam longint UNIT = 64'sd1 << 16;
   localparam longint FULL = 255 * UNIT;

   localparam int GRAD16 [16][3] = '{
      '{0,0,0},     '{0,0,0},     '{0,0,35},    '{0,2,73},
      '{4,64,103},  '{17,118,99}, '{25,151,58}, '{24,144,0},
      '{98,108,0},  '{187,15,0},  '{206,43,0},  '{215,84,0},
      '{225,125,0}, '{234,168,0}, '{244,211,0}, '{254,251,0}};
   localparam int GRAD7 [7][3] = '{
      '{0,0,0}, '{28,30,31}, '{0,24,255}, '{0,139,211}, '{247,134,0},
      '{255,255,0}, '{255,255,255}};

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [MAP_BITS-1:0]   csr_write_data;
   logic                  req_valid;
   logic                  req_ready;
   logic [LEVEL_BITS-1:0] req_level;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [CHAN_BITS-1:0]  rsp_red;
   logic [CHAN_BITS-1:0]  rsp_green;
   logic [CHAN_BITS-1:0]  rsp_blue;

   level_req_type pending_levels [$];
   rgb_type       expected_rgb [$];
   logic [3:0]    map_cur;
   level_req_type cur_req;
   bit            have_req;
   int            req_wait;
   bit            req_fire;
   int            rsp_stall;
   int            long_hold;
   bit            no_idle;
   int            mismatches;

   colormap_level_to_rgb_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_level        (req_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint floor_div(longint n, longint d);
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
   endfunction

   function automatic longint root_units(bit [63:0] x);
      bit [63:0] res;
      bit [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return longint'(res);
   endfunction

   // quarter-wave series in Q30, negative half clipped to zero
   function automatic longint sine_units(int unsigned n);
      bit [63:0] q;
      bit [63:0] r;
      bit [63:0] x;
      bit [63:0] x2;
      bit [63:0] t;
      bit [63:0] s;
      int        dens [6];
      dens = '{156, 110, 72, 42, 20, 6};
      q = (n / 255) & 3;
      r = n % 255;
      if (q >= 2) return 0;
      if (q == 1) r = 255 - r;
      x = (64'd1686629713 * r) / 255;
      x2 = (x * x) >> 30;
      t = 64'd1 << 30;
      for (int k = 0; k < 6; k++) t = (64'd1 << 30) - ((x2 * t) >> 30) / dens[k];
      s = (x * t) >> 30;
      if (s > (64'd1 << 30)) s = 64'd1 << 30;
      return longint'(((64'd255 * s) << 16) >> 30);
   endfunction

   function automatic void jet_top(int l, longint v, ref longint c [3]);
      if (8 * l < 765) begin
         c[0] = 0; c[1] = 4 * v - FULL / 2; c[2] = FULL;
      end else if (8 * l < 1275) begin
         c[0] = 4 * v - 3 * FULL / 2; c[1] = FULL; c[2] = FULL - c[0];
      end else if (8 * l < 1785) begin
         c[0] = FULL; c[1] = FULL - (4 * v - 5 * FULL / 2); c[2] = 0;
      end else begin
         c[0] = FULL - (4 * v - 7 * FULL / 2); c[1] = 0; c[2] = 0;
      end
   endfunction

   function automatic rgb_type colormap_rgb(logic [3:0] map, logic [7:0] level);
      int      l;
      int      i;
      int      sec;
      longint  v;
      longint  f;
      longint  c [3];
      longint  d;
      longint  y;
      rgb_type o;
      l = level;
      v = longint'(l) * UNIT;
      c = '{0, 0, 0};
      case (map)
         MAP_GRAY: c = '{v, v, v};
         MAP_TRAD: begin
            c[0] = root_units(64'd255 * l * (64'd1 << 32));
            c[1] = longint'(l) * l * l * UNIT / 65025;
            c[2] = sine_units(4 * l);
         end
         MAP_HOT: c = '{3 * v, 3 * v - FULL, 3 * v - 2 * FULL};
         MAP_RAINBOW: begin
            c[0] = 2 * v - FULL / 2;
            if (c[0] < 0) c[0] = -c[0];
            c[1] = sine_units(2 * l);
            c[2] = sine_units(255 - l);
         end
         MAP_JET: if (8 * l < 255) c[2] = 4 * v + FULL / 2; else jet_top(l, v, c);
         MAP_BLACKJET: if (8 * l < 255) c[2] = floor_div(32 * v, 3); else jet_top(l, v, c);
         MAP_WHITEJET: begin
            if (8 * l < 255) c = '{FULL - 8 * v, FULL - 8 * v, FULL};
            else jet_top(l, v, c);
         end
         MAP_WJSHADOW: begin
            if (8 * l < 255) c = '{FULL - 8 * v, FULL - 8 * v, FULL - 8 * v};
            else if (8 * l < 510) c[2] = 8 * v - FULL;
            else if (8 * l < 765) begin
               c[1] = 8 * v - 2 * FULL; c[2] = FULL;
            end else jet_top(l, v, c);
         end
         MAP_GRAD16: begin
            i = 1;
            while (i < 15 && l > 17 * i) i++;
            for (int k = 0; k < 3; k++) begin
               d = GRAD16[i][k] - GRAD16[i-1][k];
               c[k] = GRAD16[i-1][k] * UNIT + floor_div(2 * d * (l - 17 * (i - 1)) * UNIT, 255);
            end
         end
         MAP_GRAD7: begin
            i = 1;
            while (i < 6 && 2 * l > 85 * i) i++;
            for (int k = 0; k < 3; k++) begin
               d = GRAD7[i][k] - GRAD7[i-1][k];
               c[k] = GRAD7[i-1][k] * UNIT
                    + floor_div(d * (6 * l - 255 * (i - 1)) * UNIT, 255);
            end
         end
         MAP_WHEEL: begin
            sec = (6 * l) / 255;
            f = longint'(6 * l - 255 * sec) * UNIT;
            if (sec >= 6) sec = 0;
            case (sec)
               0: c = '{FULL, f, 0};
               1: c = '{FULL - f, FULL, 0};
               2: c = '{0, FULL, f};
               3: c = '{0, FULL - f, FULL};
               4: c = '{f, 0, FULL};
               default: c = '{FULL, 0, FULL - f};
            endcase
         end
         default: c = '{0, 0, 0};
      endcase
      for (int k = 0; k < 3; k++) begin
         y = c[k];
         if (y < 0) y = 0;
         if (y > FULL) y = FULL;
         c[k] = y >>> 16;
      end
      o.red = c[0][7:0];
      o.green = c[1][7:0];
      o.blue = c[2][7:0];
      return o;
   endfunction

   // request side: acceptance and prediction
   always @(posedge clock) begin
      req_fire = !reset && req_valid && req_ready;
      if (req_fire) expected_rgb.push_back(colormap_rgb(map_cur, req_level));
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (!have_req && pending_levels.size() > 0) begin
            cur_req = pending_levels.pop_front();
            have_req = 1;
            req_wait = cur_req.gap;
         end
         if (have_req && req_wait == 0) begin
            req_valid <= 1'b1;
            req_level <= cur_req.level;
            have_req = 0;
         end else begin
            req_valid <= 1'b0;
            if (have_req) req_wait--;
         end
      end
   end

   // result side
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rgb.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d %0d %0d",
                                           rsp_red, rsp_green, rsp_blue);
         end else begin
            rgb_type e;
            e = expected_rgb.pop_front();
            if (e.red !== rsp_red || e.green !== rsp_green || e.blue !== rsp_blue) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d %0d %0d, actual %0d %0d %0d",
                           e.red, e.green, e.blue, rsp_red, rsp_green, rsp_blue);
            end
         end
         rsp_stall = no_idle ? 0 : $urandom_range(0, 14);
      end
   end

   always @(negedge clock) begin
      if (long_hold > 0) begin
         long_hold--;
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic add_level(logic [7:0] level);
      level_req_type r;
      r.level = level;
      r.gap = no_idle ? 0 : $urandom_range(0, 14);
      pending_levels.push_back(r);
   endtask

   task automatic drain();
      while (pending_levels.size() > 0 || have_req || req_valid || expected_rgb.size() > 0)
         @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_map(logic [3:0] map);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= map;
      map_cur = map;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [7:0] edges [6];
      int         n;
      edges = '{8'd0, 8'd31, 8'd32, 8'd127, 8'd254, 8'd255};
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_level = '0;
      rsp_ready = 1'b0;
      map_cur = MAP_GRAY;
      have_req = 0;
      req_fire = 0;
      rsp_stall = 0;
      long_hold = 0;
      no_idle = 0;
      mismatches = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // gray out of reset, then every code at the edges of the level range
      foreach (edges[j]) add_level(edges[j]);
      drain();
      for (int m = 0; m < 16; m++) begin
         set_map(m[3:0]);
         add_level(edges[m % 6]);
         add_level(edges[(m + 3) % 6]);
         drain();
      end

      for (int p = 0; p < 18; p++) begin
         if (p % 5 == 0) set_map(MAP_WHEEL);
         else if (p % 5 == 1) set_map(MAP_NONE);
         else if (p % 5 == 2) set_map(4'd15);
         else set_map(4'($urandom_range(0, 15)));
         no_idle = (p % 4 == 3);
         if (p == 7) begin
            no_idle = 1;
            long_hold = 300;
         end
         n = $urandom_range(40, 60);
         for (int j = 0; j < n; j++) begin
            if ($urandom_range(0, 7) == 0) add_level(edges[$urandom_range(0, 5)]);
            else add_level(8'($urandom_range(0, 255)));
         end
         drain();
      end
      no_idle = 0;

      repeat (10) @(negedge clock);
      if (mismatches == 0 && expected_rgb.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
